FILE: hdl/tcw_pkg.sv
package tcw_pkg;

  // Screen geometry
  localparam int WIDTH    = 80;
  localparam int HEIGHT   = 25;
  localparam int CELLS    = WIDTH * HEIGHT;
  localparam int COL_W    = $clog2(WIDTH);
  localparam int ROW_W    = $clog2(HEIGHT);
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int OFF_W    = $clog2(CELLS + 1);
  localparam int SRC_W    = $clog2(2 * CELLS);
  localparam int CELL_W   = 16;
  localparam int CURSOR_W = 11;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
  localparam logic [7:0]        NEWLINE    = 8'd10;

  // Action codes
  localparam logic [2:0] ACT_PUT    = 3'd0;
  localparam logic [2:0] ACT_PUT_AT = 3'd1;
  localparam logic [2:0] ACT_SET    = 3'd2;
  localparam logic [2:0] ACT_CLEAR  = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  // Datapath micro-operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR      = 4'd1;
  localparam logic [OP_W-1:0] OP_WRITE_ADV  = 4'd2;
  localparam logic [OP_W-1:0] OP_NL_DOWN    = 4'd3;
  localparam logic [OP_W-1:0] OP_NL_SCROLL  = 4'd4;
  localparam logic [OP_W-1:0] OP_SET_ROWCOL = 4'd5;
  localparam logic [OP_W-1:0] OP_PLACE_BOT  = 4'd6;
  localparam logic [OP_W-1:0] OP_RD_ISSUE   = 4'd7;
  localparam logic [OP_W-1:0] OP_RD_CAPTURE = 4'd8;
  localparam logic [OP_W-1:0] OP_FINISH     = 4'd9;
  localparam logic [OP_W-1:0] OP_SWEEP_INIT = 4'd10;
  localparam logic [OP_W-1:0] OP_SWEEP_STEP = 4'd11;

  // Jump conditions
  localparam int COND_W = 4;
  localparam logic [COND_W-1:0] C_NEXT       = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS     = 4'd1;
  localparam logic [COND_W-1:0] C_NOT_START  = 4'd2;
  localparam logic [COND_W-1:0] C_DISPATCH   = 4'd3;
  localparam logic [COND_W-1:0] C_CALL       = 4'd4;
  localparam logic [COND_W-1:0] C_RET        = 4'd5;
  localparam logic [COND_W-1:0] C_NEWLINE    = 4'd6;
  localparam logic [COND_W-1:0] C_NOT_LAST   = 4'd7;
  localparam logic [COND_W-1:0] C_BOTTOM     = 4'd8;
  localparam logic [COND_W-1:0] C_COL_WIDE   = 4'd9;
  localparam logic [COND_W-1:0] C_ROW_BELOW  = 4'd10;
  localparam logic [COND_W-1:0] C_PUT_AFTER  = 4'd11;
  localparam logic [COND_W-1:0] C_OUT_RANGE  = 4'd12;
  localparam logic [COND_W-1:0] C_SWEEP_MORE = 4'd13;

  // Microprogram addresses
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_RESET      = 5'd0;
  localparam logic [PC_W-1:0] PC_RESET_END  = 5'd1;
  localparam logic [PC_W-1:0] PC_IDLE       = 5'd2;
  localparam logic [PC_W-1:0] PC_DISPATCH   = 5'd3;
  localparam logic [PC_W-1:0] PC_PUT        = 5'd4;
  localparam logic [PC_W-1:0] PC_PUT_WRITE  = 5'd5;
  localparam logic [PC_W-1:0] PC_PUT_SCROLL = 5'd6;
  localparam logic [PC_W-1:0] PC_PUT_END    = 5'd7;
  localparam logic [PC_W-1:0] PC_NL         = 5'd8;
  localparam logic [PC_W-1:0] PC_NL_DOWN    = 5'd9;
  localparam logic [PC_W-1:0] PC_NL_BOT     = 5'd10;
  localparam logic [PC_W-1:0] PC_NL_END     = 5'd11;
  localparam logic [PC_W-1:0] PC_PLACE      = 5'd12;
  localparam logic [PC_W-1:0] PC_PLACE_ROW  = 5'd13;
  localparam logic [PC_W-1:0] PC_PLACE_SET  = 5'd14;
  localparam logic [PC_W-1:0] PC_PLACE_BOT  = 5'd15;
  localparam logic [PC_W-1:0] PC_PLACE_END  = 5'd16;
  localparam logic [PC_W-1:0] PC_PLACE_DONE = 5'd17;
  localparam logic [PC_W-1:0] PC_CLEAR      = 5'd18;
  localparam logic [PC_W-1:0] PC_CLEAR_END  = 5'd19;
  localparam logic [PC_W-1:0] PC_READ       = 5'd20;
  localparam logic [PC_W-1:0] PC_READ_CAP   = 5'd21;
  localparam logic [PC_W-1:0] PC_DONE       = 5'd22;
  localparam logic [PC_W-1:0] PC_SWEEP      = 5'd23;
  localparam logic [PC_W-1:0] PC_SWEEP_LOOP = 5'd24;
  localparam logic [PC_W-1:0] PC_SWEEP_RET  = 5'd25;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] char_code;
    logic [7:0] text_color;
    logic [7:0] cell_row;
    logic [7:0] cell_col;
  } item_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_pos;
    logic [CELL_W-1:0]   read_value;
    logic                scrolled;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } uword_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            accept;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] action;
    logic       newline;
    logic       col_wide;
    logic       row_below;
    logic       out_range;
    logic       put_after;
    logic       last;
    logic       bottom;
    logic       sweep_more;
  } status_t;

  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    unique case (pc)
      PC_RESET:      ucode_rom = '{op: OP_CLEAR,      cond: C_CALL,       target: PC_SWEEP};
      PC_RESET_END:  ucode_rom = '{op: OP_NOP,        cond: C_ALWAYS,     target: PC_IDLE};
      PC_IDLE:       ucode_rom = '{op: OP_NOP,        cond: C_NOT_START,  target: PC_IDLE};
      PC_DISPATCH:   ucode_rom = '{op: OP_NOP,        cond: C_DISPATCH,   target: PC_DONE};
      PC_PUT:        ucode_rom = '{op: OP_NOP,        cond: C_NEWLINE,    target: PC_NL};
      PC_PUT_WRITE:  ucode_rom = '{op: OP_WRITE_ADV,  cond: C_NOT_LAST,   target: PC_DONE};
      PC_PUT_SCROLL: ucode_rom = '{op: OP_NOP,        cond: C_CALL,       target: PC_SWEEP};
      PC_PUT_END:    ucode_rom = '{op: OP_NOP,        cond: C_ALWAYS,     target: PC_DONE};
      PC_NL:         ucode_rom = '{op: OP_NOP,        cond: C_BOTTOM,     target: PC_NL_BOT};
      PC_NL_DOWN:    ucode_rom = '{op: OP_NL_DOWN,    cond: C_ALWAYS,     target: PC_DONE};
      PC_NL_BOT:     ucode_rom = '{op: OP_NL_SCROLL,  cond: C_CALL,       target: PC_SWEEP};
      PC_NL_END:     ucode_rom = '{op: OP_NOP,        cond: C_ALWAYS,     target: PC_DONE};
      PC_PLACE:      ucode_rom = '{op: OP_NOP,        cond: C_COL_WIDE,   target: PC_PLACE_END};
      PC_PLACE_ROW:  ucode_rom = '{op: OP_NOP,        cond: C_ROW_BELOW,  target: PC_PLACE_BOT};
      PC_PLACE_SET:  ucode_rom = '{op: OP_SET_ROWCOL, cond: C_ALWAYS,     target: PC_PLACE_END};
      PC_PLACE_BOT:  ucode_rom = '{op: OP_PLACE_BOT,  cond: C_CALL,       target: PC_SWEEP};
      PC_PLACE_END:  ucode_rom = '{op: OP_NOP,        cond: C_PUT_AFTER,  target: PC_PUT};
      PC_PLACE_DONE: ucode_rom = '{op: OP_NOP,        cond: C_ALWAYS,     target: PC_DONE};
      PC_CLEAR:      ucode_rom = '{op: OP_CLEAR,      cond: C_CALL,       target: PC_SWEEP};
      PC_CLEAR_END:  ucode_rom = '{op: OP_NOP,        cond: C_ALWAYS,     target: PC_DONE};
      PC_READ:       ucode_rom = '{op: OP_RD_ISSUE,   cond: C_OUT_RANGE,  target: PC_DONE};
      PC_READ_CAP:   ucode_rom = '{op: OP_RD_CAPTURE, cond: C_NEXT,       target: PC_DONE};
      PC_DONE:       ucode_rom = '{op: OP_FINISH,     cond: C_ALWAYS,     target: PC_IDLE};
      PC_SWEEP:      ucode_rom = '{op: OP_SWEEP_INIT, cond: C_NEXT,       target: PC_SWEEP_LOOP};
      PC_SWEEP_LOOP: ucode_rom = '{op: OP_SWEEP_STEP, cond: C_SWEEP_MORE, target: PC_SWEEP_LOOP};
      PC_SWEEP_RET:  ucode_rom = '{op: OP_NOP,        cond: C_RET,        target: PC_IDLE};
      default:       ucode_rom = '{op: OP_NOP,        cond: C_ALWAYS,     target: PC_IDLE};
    endcase
  endfunction

  function automatic logic [PC_W-1:0] dispatch_pc(input logic [2:0] action);
    unique case (action) inside
      ACT_PUT:             dispatch_pc = PC_PUT;
      ACT_PUT_AT, ACT_SET: dispatch_pc = PC_PLACE;
      ACT_CLEAR:           dispatch_pc = PC_CLEAR;
      ACT_READ:            dispatch_pc = PC_READ;
      default:             dispatch_pc = PC_DONE;
    endcase
  endfunction

endpackage

FILE: hdl/tcw_sequencer.sv
module tcw_sequencer
  import tcw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t stat,
  output ctrl_t   ctrl,
  output logic    busy
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic [PC_W-1:0] ret;
  logic [PC_W-1:0] ret_next;
  uword_t          uw;

  assign uw          = ucode_rom(pc);
  assign busy        = (pc != PC_IDLE);
  assign ctrl.op     = uw.op;
  assign ctrl.accept = (pc == PC_IDLE) && start;

  always_comb begin
    pc_next  = pc + 1'b1;
    ret_next = ret;
    unique case (uw.cond)
      C_NEXT:       ;
      C_ALWAYS:     pc_next = uw.target;
      C_NOT_START:  if (!start) pc_next = uw.target;
      C_DISPATCH:   pc_next = dispatch_pc(stat.action);
      C_CALL: begin
        pc_next  = uw.target;
        ret_next = pc + 1'b1;
      end
      C_RET:        pc_next = ret;
      C_NEWLINE:    if (stat.newline) pc_next = uw.target;
      C_NOT_LAST:   if (!stat.last) pc_next = uw.target;
      C_BOTTOM:     if (stat.bottom) pc_next = uw.target;
      C_COL_WIDE:   if (stat.col_wide) pc_next = uw.target;
      C_ROW_BELOW:  if (stat.row_below) pc_next = uw.target;
      C_PUT_AFTER:  if (stat.put_after) pc_next = uw.target;
      C_OUT_RANGE:  if (stat.out_range) pc_next = uw.target;
      C_SWEEP_MORE: if (stat.sweep_more) pc_next = uw.target;
      default:      pc_next = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= PC_RESET;
      ret <= PC_IDLE;
    end else begin
      pc  <= pc_next;
      ret <= ret_next;
    end
  end

endmodule

FILE: hdl/tcw_datapath.sv
module tcw_datapath
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  item_t             item,
  input  ctrl_t             ctrl,
  output status_t           stat,
  output logic [ADDR_W-1:0] cur_addr,
  output logic [CELL_W-1:0] read_value,
  output logic              scrolled
);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata;
  logic [ADDR_W-1:0] raddr;

  item_t             item_q;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [OFF_W-1:0]  off;
  logic [ADDR_W-1:0] idx;
  logic [SRC_W-1:0]  src;
  logic              src_ok;
  logic [ADDR_W-1:0] item_addr;

  // pending sweep write, made in the cycle after its read
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_blank;

  assign cur_addr  = ADDR_W'(int'(cur_row) * WIDTH + int'(cur_col));
  assign item_addr = ADDR_W'(int'(item_q.cell_row) * WIDTH + int'(item_q.cell_col));
  assign src       = SRC_W'(idx) + SRC_W'(off);
  assign src_ok    = (src < SRC_W'(CELLS));

  always_comb begin
    stat.action     = item_q.action;
    stat.newline    = (item_q.char_code == NEWLINE);
    stat.col_wide   = (int'(item_q.cell_col) >= WIDTH);
    stat.row_below  = (int'(item_q.cell_row) >= HEIGHT);
    stat.out_range  = stat.col_wide || stat.row_below;
    stat.put_after  = (item_q.action == ACT_PUT_AT);
    stat.bottom     = (cur_row == ROW_W'(HEIGHT - 1));
    stat.last       = stat.bottom && (cur_col == COL_W'(WIDTH - 1));
    stat.sweep_more = (idx != ADDR_W'(CELLS - 1));
  end

  always_comb begin
    raddr = '0;
    if (ctrl.op == OP_SWEEP_STEP && src_ok) begin
      raddr = src[ADDR_W-1:0];
    end else if (ctrl.op == OP_RD_ISSUE && !stat.out_range) begin
      raddr = item_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_pend) begin
      mem[wr_addr] <= wr_blank ? BLANK_CELL : rdata;
    end else if (ctrl.op == OP_WRITE_ADV) begin
      mem[cur_addr] <= {item_q.text_color, item_q.char_code};
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row  <= '0;
      cur_col  <= '0;
      wr_pend  <= 1'b0;
      scrolled <= 1'b0;
    end else begin
      wr_pend <= (ctrl.op == OP_SWEEP_STEP);
      if (ctrl.accept) begin
        item_q     <= item;
        scrolled   <= 1'b0;
        read_value <= '0;
      end
      unique case (ctrl.op)
        OP_CLEAR: begin
          off     <= OFF_W'(CELLS);
          cur_row <= '0;
          cur_col <= '0;
        end
        OP_WRITE_ADV: begin
          if (cur_col == COL_W'(WIDTH - 1)) begin
            cur_col <= '0;
            if (stat.bottom) begin
              off      <= OFF_W'(WIDTH);
              scrolled <= 1'b1;
            end else begin
              cur_row <= cur_row + 1'b1;
            end
          end else begin
            cur_col <= cur_col + 1'b1;
          end
        end
        OP_NL_DOWN: begin
          cur_row <= cur_row + 1'b1;
          cur_col <= '0;
        end
        OP_NL_SCROLL: begin
          cur_col  <= '0;
          off      <= OFF_W'(WIDTH);
          scrolled <= 1'b1;
        end
        OP_SET_ROWCOL: begin
          cur_row <= item_q.cell_row[ROW_W-1:0];
          cur_col <= item_q.cell_col[COL_W-1:0];
        end
        OP_PLACE_BOT: begin
          cur_row  <= ROW_W'(HEIGHT - 1);
          cur_col  <= item_q.cell_col[COL_W-1:0];
          scrolled <= 1'b1;
          if (int'(item_q.cell_row) >= 2 * HEIGHT - 1) begin
            off <= OFF_W'(CELLS);
          end else begin
            off <= OFF_W'((int'(item_q.cell_row) - (HEIGHT - 1)) * WIDTH);
          end
        end
        OP_RD_CAPTURE: read_value <= rdata;
        OP_SWEEP_INIT: idx <= '0;
        OP_SWEEP_STEP: begin
          idx      <= idx + 1'b1;
          wr_addr  <= idx;
          wr_blank <= !src_ok;
        end
        default: ;
      endcase
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (int'(cur_row) < HEIGHT) && (int'(cur_col) < WIDTH))
    else $error("cursor left the screen");

  a_pend_from_step: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> $past(ctrl.op == OP_SWEEP_STEP))
    else $error("sweep write without a sweep read");

  a_port_clash: assert property (@(posedge clk) disable iff (rst)
    !(wr_pend && ctrl.op == OP_WRITE_ADV))
    else $error("sweep write collides with character write");

endmodule

FILE: hdl/text_console_writer.sv
// Scrolls: each scroll or clear walks the store once.
// Requests: one at a time; busy drops in the cycle of the strobe. A placement
//   below the bottom followed by a put that scrolls again walks the store twice.
// Reset: synchronous, active high; afterwards a clearing pass blanks every cell with
//   busy high. done is a one-cycle strobe and cannot be stalled.
module text_console_writer
  import tcw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result
);

  ctrl_t             ctrl;
  status_t           stat;
  logic [ADDR_W-1:0] cur_addr;
  logic [CELL_W-1:0] read_value;
  logic              scrolled;

  // Microprogram sequencer: step counter, return register and the control-word table.
  // It walks the table for the request's action and drives one op per cycle.
  tcw_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // Datapath: cursor row/column, cell memory and the scroll sweep. A scroll by n rows
  // is one pass that copies cell i+n*WIDTH into cell i, or writes a blank where the
  // source lies past the screen; clear and the reset pass are the same sweep with
  // the offset set to the whole screen.
  tcw_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .ctrl       (ctrl),
    .stat       (stat),
    .cur_addr   (cur_addr),
    .read_value (read_value),
    .scrolled   (scrolled)
  );

  // Result register: load on the finishing step and raise the strobe for one cycle.
  // The next request may be taken in the cycle the strobe is shown; the result holds
  // until the next finishing step.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctrl.op == OP_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_FINISH) begin
      result.cursor_pos <= CURSOR_W'(cur_addr);
      result.read_value <= read_value;
      result.scrolled   <= scrolled;
    end
  end

  // The finishing step always jumps back to idle, so the strobe is never raised twice in a row.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // A taken request leaves idle at once, so no second request slips in behind it.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but sequencer stayed idle");

endmodule
